@@ rtl/wfu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package wfu_pkg;

  // length field of the result channel
  localparam int unsigned OUT_LEN_W = 64;

  // length codes of the second header byte
  localparam logic [6:0] LEN_CODE_MASK = 7'h7F;
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // extended length byte counts
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // frame status codes
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_TRUNCATED = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } beat_t;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] payload_length;
    logic                 frame_status;
    logic                 frame_done;
    logic                 byte_valid;
    logic [7:0]           payload_byte;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/wfu_in_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wfu_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire wfu_pkg::beat_t in_beat,
  input  wire logic          advance,
  output logic               hold_valid,
  output wfu_pkg::beat_t     hold_beat
);

  logic           valid_r;
  logic           valid_nxt;
  wfu_pkg::beat_t beat_r;
  logic           take;

  assign in_ready   = !valid_r || advance;
  assign take       = in_valid && in_ready;
  assign hold_valid = valid_r;
  assign hold_beat  = beat_r;

  always_comb begin
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // data register, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      beat_r <= in_beat;
    end
  end

endmodule

`default_nettype wire

@@ rtl/wfu_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wfu_parser #(
  parameter int unsigned LenW = 64
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire wfu_pkg::beat_t beat,
  input  wire logic           fire,
  output logic                has_result,
  output wfu_pkg::result_t    result
);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_LENCODE,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD,
    PH_TRAIL
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [3:0]      ext_left_r, ext_left_nxt;
  logic [LenW-1:0] len_r, len_nxt;
  logic            ovf_r, ovf_nxt;
  logic [31:0]     key_r, key_nxt;
  logic [1:0]      mseen_r, mseen_nxt;
  logic [LenW-1:0] count_r, count_nxt;

  logic [6:0]      code;
  logic [LenW-1:0] len_shift;
  logic            len_lost;
  logic [7:0]      mask_byte;
  logic            pvalid;
  logic [7:0]      pbyte;

  assign code      = beat.rx_byte[6:0] & wfu_pkg::LEN_CODE_MASK;
  assign len_shift = {len_r[LenW-9:0], beat.rx_byte};
  // bits pushed out of the top of the length accumulator
  assign len_lost  = |len_r[LenW-1 -: 8];

  always_comb begin
    unique case (count_r[1:0])
      2'd0:    mask_byte = key_r[31:24];
      2'd1:    mask_byte = key_r[23:16];
      2'd2:    mask_byte = key_r[15:8];
      2'd3:    mask_byte = key_r[7:0];
      default: mask_byte = key_r[31:24];
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    ext_left_nxt = ext_left_r;
    len_nxt      = len_r;
    ovf_nxt      = ovf_r;
    key_nxt      = key_r;
    mseen_nxt    = mseen_r;
    count_nxt    = count_r;
    pvalid       = 1'b0;
    pbyte        = 8'd0;

    unique case (phase_r)
      PH_FIRST: begin
        phase_nxt = PH_LENCODE;
      end
      PH_LENCODE: begin
        len_nxt = '0;
        ovf_nxt = 1'b0;
        if (code == wfu_pkg::LEN_CODE_EXT16) begin
          ext_left_nxt = wfu_pkg::EXT16_BYTES;
          phase_nxt    = PH_EXTLEN;
        end else if (code == wfu_pkg::LEN_CODE_EXT64) begin
          ext_left_nxt = wfu_pkg::EXT64_BYTES;
          phase_nxt    = PH_EXTLEN;
        end else begin
          len_nxt   = LenW'(code);
          mseen_nxt = 2'd0;
          phase_nxt = PH_MASK;
        end
      end
      PH_EXTLEN: begin
        ext_left_nxt = ext_left_r - 4'd1;
        ovf_nxt      = ovf_r | len_lost;
        len_nxt      = len_shift;
        if (ext_left_r == 4'd1) begin
          // saturate a length that does not fit
          if (ovf_r || len_lost) begin
            len_nxt = '1;
          end
          mseen_nxt = 2'd0;
          phase_nxt = PH_MASK;
        end
      end
      PH_MASK: begin
        key_nxt   = {key_r[23:0], beat.rx_byte};
        mseen_nxt = mseen_r + 2'd1;
        if (mseen_r == 2'd3) begin
          count_nxt = '0;
          phase_nxt = (len_r == '0) ? PH_TRAIL : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        pvalid    = 1'b1;
        pbyte     = beat.rx_byte ^ mask_byte;
        count_nxt = count_r + LenW'(1);
        if (count_nxt == len_r) begin
          phase_nxt = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        // trailing bytes are dropped
      end
      default: begin
        phase_nxt = PH_FIRST;
      end
    endcase
  end

  always_comb begin
    has_result            = pvalid || beat.buffer_end;
    result.payload_byte   = pbyte;
    result.byte_valid     = pvalid;
    result.frame_done     = beat.buffer_end;
    result.frame_status   = wfu_pkg::STATUS_OK;
    result.payload_length = '0;
    if (beat.buffer_end) begin
      result.frame_status = (phase_nxt == PH_TRAIL) ? wfu_pkg::STATUS_OK
                                                    : wfu_pkg::STATUS_TRUNCATED;
      if (phase_nxt == PH_MASK || phase_nxt == PH_PAYLOAD || phase_nxt == PH_TRAIL) begin
        result.payload_length = wfu_pkg::OUT_LEN_W'(len_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_FIRST;
      ext_left_r <= 4'd0;
      len_r      <= '0;
      ovf_r      <= 1'b0;
      key_r      <= 32'd0;
      mseen_r    <= 2'd0;
      count_r    <= '0;
    end else if (fire) begin
      if (beat.buffer_end) begin
        // buffer over: next beat starts a new frame
        phase_r    <= PH_FIRST;
        ext_left_r <= 4'd0;
        len_r      <= '0;
        ovf_r      <= 1'b0;
        key_r      <= 32'd0;
        mseen_r    <= 2'd0;
        count_r    <= '0;
      end else begin
        phase_r    <= phase_nxt;
        ext_left_r <= ext_left_nxt;
        len_r      <= len_nxt;
        ovf_r      <= ovf_nxt;
        key_r      <= key_nxt;
        mseen_r    <= mseen_nxt;
        count_r    <= count_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/wfu_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module wfu_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire wfu_pkg::result_t load_result,
  output logic                  space,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output wfu_pkg::result_t      out_result
);

  logic             valid_r;
  logic             valid_nxt;
  wfu_pkg::result_t result_r;

  assign space      = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= load_result;
    end
  end

endmodule

`default_nettype wire

@@ rtl/websocket_frame_unmasker_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// an accepted beat waits in the input register and moves into the result register
// once the result side is free; bytes that give no result leave no output beat
// throughput: one beat per cycle from the single parse step unless out_tready stalls
// reset: synchronous active-low rst_n empties both registers and returns the
// parser to the first header byte of a new frame

module websocket_frame_unmasker_core #(
  parameter int unsigned LENGTH_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tlast,   // buffer_end

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // [7:0] payload_byte, [71:8] payload_length
  output logic [1:0]       out_tuser,  // [0] byte_valid, [1] frame_status
  output logic             out_tlast   // frame_done
);

  wfu_pkg::beat_t   in_beat;
  wfu_pkg::beat_t   hold_beat;
  logic             hold_valid;
  logic             advance;
  logic             has_result;
  logic             out_space;
  logic             load;
  wfu_pkg::result_t parse_result;
  wfu_pkg::result_t out_result;

  assign in_beat.rx_byte    = in_tdata;
  assign in_beat.buffer_end = in_tlast;

  // a held beat moves on when it makes no result or the result register has room
  assign advance = hold_valid && (!has_result || out_space);
  assign load    = advance && has_result;

  // input register
  wfu_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_beat    (in_beat),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_beat  (hold_beat)
  );

  // header parse, mask capture and unmask; state steps when the beat advances
  wfu_parser #(
    .LenW (LENGTH_WIDTH)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat       (hold_beat),
    .fire       (advance),
    .has_result (has_result),
    .result     (parse_result)
  );

  // result register, takes a new beat while the old one is being drained
  wfu_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (load),
    .load_result (parse_result),
    .space       (out_space),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_result  (out_result)
  );

  assign out_tdata = {out_result.payload_length, out_result.payload_byte};
  assign out_tuser = {out_result.frame_status, out_result.byte_valid};
  assign out_tlast = out_result.frame_done;

endmodule

`default_nettype wire
